@@ hdl/pcm_pkg.sv @@
// shared types and constants for the pwm capture to motion block
package pcm_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned EDGE_TIME_W    = 32;
  localparam int unsigned QUOT_W         = 36;
  localparam int unsigned CNT_W          = 6;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam int unsigned ITER_FREQ  = 28;
  localparam int unsigned ITER_SPEED = 36;
  localparam int unsigned ITER_DUTY  = 15;
  localparam int unsigned ITER_FRAC  = 17;

  localparam logic [27:0] FREQ_NUM    = 28'd256000000;
  localparam logic [19:0] SPEED_NUM   = 20'd1000000;
  localparam logic [19:0] GRAVITY_Q16 = 20'd642689;

  localparam logic [CFG_DATA_W-1:0] SPEED_SCALE_RST = 16'd128;
  localparam logic [CFG_DATA_W-1:0] ACCEL_MAX_G_RST = 16'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SCALE = 4'd0,
    REG_ACCEL_MAX_G = 4'd1
  } pcm_reg_e;

  typedef struct packed {
    logic [EDGE_TIME_W-1:0] edge_time_us;
    logic                   new_level;
  } pcm_in_t;

  typedef struct packed {
    logic        wave_valid;
    logic [27:0] frequency_q8;
    logic [14:0] duty_q8;
    logic [35:0] speed_q8;
    logic [19:0] accel_q8;
  } pcm_out_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
  } pcm_div_ctl_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } pcm_div_rsp_t;

endpackage

@@ hdl/pcm_div.sv @@
// shared shift-subtract divider, one quotient bit per cycle
module pcm_div #(
  parameter int unsigned TIME_WIDTH = pcm_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pcm_pkg::pcm_div_ctl_t      ctl_i,
  input  logic [TIME_WIDTH-1:0]      rinit_i,
  input  logic [pcm_pkg::QUOT_W-1:0] num_i,
  input  logic [TIME_WIDTH-1:0]      den_i,
  output pcm_pkg::pcm_div_rsp_t      rsp_o
);
  import pcm_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] r_q, r_d;
  logic [TIME_WIDTH-1:0] den_q, den_d;
  logic [QUOT_W-1:0]     num_q, num_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [TIME_WIDTH:0]   rs;
  logic [TIME_WIDTH:0]   rs_sub;
  logic                  ge;

  assign rs     = {r_q, num_q[QUOT_W-1]};
  assign ge     = rs >= {1'b0, den_q};
  assign rs_sub = rs - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    den_d  = den_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ctl_i.iters;
      r_d    = rinit_i;
      den_d  = den_i;
      num_d  = num_i;
      quot_d = '0;
    end else if (busy_q) begin
      r_d    = ge ? rs_sub[TIME_WIDTH-1:0] : rs[TIME_WIDTH-1:0];
      num_d  = {num_q[QUOT_W-2:0], 1'b0};
      quot_d = {quot_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    den_q  <= den_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

@@ hdl/pcm_seq.sv @@
// edge state, sequencer over the shared divider, accel product and result register
module pcm_seq #(
  parameter int unsigned TIME_WIDTH = pcm_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcm_pkg::pcm_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcm_pkg::pcm_out_t              out_data_o,
  input  logic [pcm_pkg::CFG_DATA_W-1:0] speed_scale_i,
  input  logic [pcm_pkg::CFG_DATA_W-1:0] accel_max_g_i,
  output pcm_pkg::pcm_div_ctl_t          div_ctl_o,
  output logic [TIME_WIDTH-1:0]          div_rinit_o,
  output logic [pcm_pkg::QUOT_W-1:0]     div_num_o,
  output logic [TIME_WIDTH-1:0]          div_den_o,
  input  pcm_pkg::pcm_div_rsp_t          div_rsp_i
);
  import pcm_pkg::*;

  localparam int unsigned DUTY_NUM_W = TIME_WIDTH + ITER_DUTY;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL1 = 6'b001000,
    S_MUL2 = 6'b010000,
    S_FIN  = 6'b100000
  } pcm_state_e;

  typedef enum logic [1:0] {
    OP_FREQ  = 2'd0,
    OP_SPEED = 2'd1,
    OP_DUTY  = 2'd2,
    OP_FRAC  = 2'd3
  } pcm_op_e;

  pcm_state_e state_q, state_d;
  pcm_op_e    op_q, op_d;
  pcm_op_e    start_op;

  logic [TIME_WIDTH-1:0] rise_q, rise_d;
  logic [TIME_WIDTH-1:0] period_q, period_d;
  logic [TIME_WIDTH-1:0] high_q, high_d;
  logic                  seen_q, seen_d;
  logic                  known_q, known_d;
  logic                  ok_q, ok_d;
  logic                  out_valid_q, out_valid_d;

  logic [27:0] freq_q, freq_d;
  logic [35:0] speed_q, speed_d;
  logic [14:0] duty_q, duty_d;
  logic [16:0] frac_q, frac_d;
  logic [32:0] prod1_q, prod1_d;
  logic [52:0] prod2_q, prod2_d;
  pcm_out_t    out_q, out_d;

  logic                  accept;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  ok;
  logic                  launch;
  logic                  out_free;
  logic [DUTY_NUM_W-1:0] duty_num;
  logic [QUOT_W-1:0]     speed_num;

  assign accept   = in_valid_i && in_ready_o;
  assign now      = TIME_WIDTH'(in_data_i.edge_time_us);
  assign elapsed  = now - rise_q;
  assign ok       = known_q && (period_q != '0) && (high_q <= period_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign duty_num  = (DUTY_NUM_W'(high_q) << 14) + (DUTY_NUM_W'(high_q) << 13)
                   + (DUTY_NUM_W'(high_q) << 10);
  assign speed_num = QUOT_W'(SPEED_NUM) * QUOT_W'(speed_scale_i);

  always_comb begin
    start_op = OP_FREQ;
    if (state_q != S_CHK) begin
      case (op_q)
        OP_FREQ:  start_op = OP_SPEED;
        OP_SPEED: start_op = OP_DUTY;
        default:  start_op = OP_FRAC;
      endcase
    end
  end

  assign launch = (state_q == S_CHK && ok)
               || (state_q == S_DIV && div_rsp_i.done && op_q != OP_FRAC);

  always_comb begin
    div_ctl_o.start = launch;
    div_ctl_o.iters = CNT_W'(ITER_FREQ);
    div_rinit_o     = '0;
    div_num_o       = QUOT_W'(FREQ_NUM) << (QUOT_W - ITER_FREQ);
    unique case (start_op)
      OP_FREQ: begin
        div_ctl_o.iters = CNT_W'(ITER_FREQ);
      end
      OP_SPEED: begin
        div_ctl_o.iters = CNT_W'(ITER_SPEED);
        div_num_o       = speed_num;
      end
      OP_DUTY: begin
        div_ctl_o.iters = CNT_W'(ITER_DUTY);
        div_rinit_o     = duty_num[DUTY_NUM_W-1:ITER_DUTY];
        div_num_o       = QUOT_W'(duty_num[ITER_DUTY-1:0]) << (QUOT_W - ITER_DUTY);
      end
      OP_FRAC: begin
        div_ctl_o.iters = CNT_W'(ITER_FRAC);
        div_rinit_o     = high_q >> 1;
        div_num_o       = {high_q[0], {(QUOT_W-1){1'b0}}};
      end
      default: begin
        div_ctl_o.iters = CNT_W'(ITER_FREQ);
      end
    endcase
  end

  assign div_den_o = period_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rise_d      = rise_q;
    period_d    = period_q;
    high_d      = high_q;
    seen_d      = seen_q;
    known_d     = known_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q;
    freq_d      = freq_q;
    speed_d     = speed_q;
    duty_d      = duty_q;
    frac_d      = frac_q;
    prod1_d     = prod1_q;
    prod2_d     = prod2_q;
    out_d       = out_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (launch) begin
      op_d = start_op;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.new_level) begin
            if (seen_q) begin
              period_d = elapsed;
              known_d  = 1'b1;
            end
            rise_d = now;
            seen_d = 1'b1;
          end else if (seen_q) begin
            high_d = elapsed;
          end
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        ok_d    = ok;
        state_d = ok ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          unique case (op_q)
            OP_FREQ:  freq_d  = div_rsp_i.quot[27:0];
            OP_SPEED: speed_d = div_rsp_i.quot;
            OP_DUTY:  duty_d  = div_rsp_i.quot[14:0];
            OP_FRAC:  frac_d  = div_rsp_i.quot[16:0];
            default:  freq_d  = freq_q;
          endcase
          if (op_q == OP_FRAC) begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod1_d = 33'(frac_q) * 33'(accel_max_g_i);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod2_d = 53'(prod1_q) * 53'(GRAVITY_Q16);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (ok_q) begin
            out_d.wave_valid   = 1'b1;
            out_d.frequency_q8 = freq_q;
            out_d.duty_q8      = duty_q;
            out_d.speed_q8     = speed_q;
            out_d.accel_q8     = prod2_q[51:32];
          end else begin
            out_d = '0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_FREQ;
      rise_q      <= '0;
      period_q    <= '0;
      high_q      <= '0;
      seen_q      <= 1'b0;
      known_q     <= 1'b0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      rise_q      <= rise_d;
      period_q    <= period_d;
      high_q      <= high_d;
      seen_q      <= seen_d;
      known_q     <= known_d;
      ok_q        <= ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q  <= freq_d;
    speed_q <= speed_d;
    duty_q  <= duty_d;
    frac_q  <= frac_d;
    prod1_q <= prod1_d;
    prod2_q <= prod2_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/pwm_capture_to_motion.sv @@
// pwm capture to motion top level: config registers, sequencer and shared divider
// for a valid wave the shared divider yields one quotient bit per cycle over four divisions (96 bits)
// items are taken one at a time: a new item is accepted only once the previous one has left the sequencer
// reset: asynchronous active low, clears edge state, restores default scale registers
module pwm_capture_to_motion #(
  parameter int unsigned TIME_WIDTH = pcm_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pcm_pkg::pcm_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pcm_pkg::pcm_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pcm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pcm_pkg::*;

  logic [CFG_DATA_W-1:0] speed_scale_q, speed_scale_d;
  logic [CFG_DATA_W-1:0] accel_max_g_q, accel_max_g_d;
  pcm_div_ctl_t          div_ctl;
  pcm_div_rsp_t          div_rsp;
  logic [TIME_WIDTH-1:0] div_rinit;
  logic [QUOT_W-1:0]     div_num;
  logic [TIME_WIDTH-1:0] div_den;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    speed_scale_d = speed_scale_q;
    accel_max_g_d = accel_max_g_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SPEED_SCALE: speed_scale_d = cfg_data_i;
        REG_ACCEL_MAX_G: accel_max_g_d = cfg_data_i;
        default:         speed_scale_d = speed_scale_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_scale_q <= SPEED_SCALE_RST;
      accel_max_g_q <= ACCEL_MAX_G_RST;
    end else begin
      speed_scale_q <= speed_scale_d;
      accel_max_g_q <= accel_max_g_d;
    end
  end

  pcm_seq #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .speed_scale_i(speed_scale_q),
    .accel_max_g_i(accel_max_g_q),
    .div_ctl_o    (div_ctl),
    .div_rinit_o  (div_rinit),
    .div_num_o    (div_num),
    .div_den_o    (div_den),
    .div_rsp_i    (div_rsp)
  );

  pcm_div #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .rinit_i(div_rinit),
    .num_i  (div_num),
    .den_i  (div_den),
    .rsp_o  (div_rsp)
  );

endmodule

@@ hdl/pcm_chk.sv @@
// port level checker for pwm_capture_to_motion and its bind
module pcm_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pcm_pkg::pcm_out_t out_data_o
);
  import pcm_pkg::*;

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result item changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous one in flight");

  // invalid wave gives all-zero figures
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.wave_valid |->
      out_data_o.frequency_q8 == '0 && out_data_o.duty_q8 == '0 &&
      out_data_o.speed_q8 == '0 && out_data_o.accel_q8 == '0)
    else $error("invalid result carries nonzero figures");

  // duty never above full scale
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_q8 <= 15'd25600)
    else $error("duty above full scale");

endmodule

bind pwm_capture_to_motion pcm_chk u_pcm_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ tb/pwm_capture_to_motion_tb.sv @@
// testbench for pwm_capture_to_motion: queued edge stimulus, random stalls, motion figure checks
module pwm_capture_to_motion_tb;
  import pcm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = 4'd9;

  localparam longint unsigned HZ_Q8_NUM     = 64'd256000000;
  localparam longint unsigned DUTY_Q8_SCALE = 64'd25600;
  localparam longint unsigned SPEED_NUM_US  = 64'd1000000;
  localparam longint unsigned G_Q16         = 64'd642689;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  pcm_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  pcm_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  pwm_capture_to_motion u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // edge capture mirror
  logic [31:0]           rise_time_q    = '0;
  logic [31:0]           period_q       = '0;
  logic [31:0]           high_q         = '0;
  bit                    seen_rise_q    = 1'b0;
  bit                    period_known_q = 1'b0;
  logic [CFG_DATA_W-1:0] speed_scale_q  = 16'd128;
  logic [CFG_DATA_W-1:0] accel_max_g_q  = 16'd1024;

  pcm_in_t     pending_edges[$];
  pcm_out_t    expected_motion[$];
  int unsigned mismatch_cnt = 0;
  bit          in_fire      = 1'b0;
  int unsigned stall_cycles = 0;

  bit          no_idle_send = 1'b0;
  bit          no_idle_recv = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  bit          hold_req     = 1'b0;
  bit          hold_begun   = 1'b0;
  int unsigned hold_cnt     = 0;
  logic [31:0] t_cur        = '0;

  function automatic pcm_out_t predict_motion(pcm_in_t item);
    pcm_out_t    res;
    logic [63:0] p, h, frac, prod;
    res = '0;
    if (item.new_level) begin
      if (seen_rise_q) begin
        period_q       = item.edge_time_us - rise_time_q;
        period_known_q = 1'b1;
      end
      rise_time_q = item.edge_time_us;
      seen_rise_q = 1'b1;
    end else if (seen_rise_q) begin
      high_q = item.edge_time_us - rise_time_q;
    end
    p = {32'd0, period_q};
    h = {32'd0, high_q};
    if (period_known_q && p != 0 && h <= p) begin
      frac             = (h << 16) / p;
      prod             = frac * {48'd0, accel_max_g_q} * G_Q16;
      res.wave_valid   = 1'b1;
      res.frequency_q8 = 28'(HZ_Q8_NUM / p);
      res.duty_q8      = 15'((h * DUTY_Q8_SCALE) / p);
      res.speed_q8     = 36'((SPEED_NUM_US * {48'd0, speed_scale_q}) / p);
      res.accel_q8     = 20'(prod >> 32);
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap(bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 32'd0;
    if (r < 35) return $urandom_range(1, 64);
    if (r < 75) return $urandom_range(65, 20000);
    if (r < 95) return $urandom_range(20001, 5000000);
    return $urandom;
  endfunction

  // driver
  always @(negedge clk_i) begin : drive_edges
    logic    v;
    pcm_in_t d;
    v = in_valid_i;
    d = in_data_i;
    if (in_fire) v = 1'b0;
    if (!v && rst_ni) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (pending_edges.size() > 0) begin
        d = pending_edges.pop_front();
        v = 1'b1;
        if ($urandom_range(0, 79) == 0) no_idle_send = !no_idle_send;
        send_gap = pick_gap(no_idle_send);
      end
    end
    in_valid_i <= v;
    in_data_i  <= d;
  end

  // receiver
  always @(negedge clk_i) begin : drive_ready
    logic r;
    if (hold_req && !hold_begun) begin
      hold_begun = 1'b1;
      hold_cnt   = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      r = 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap = recv_gap - 1;
      r = 1'b0;
    end else begin
      r = 1'b1;
      if ($urandom_range(0, 99) == 0) no_idle_recv = !no_idle_recv;
      if ($urandom_range(0, 3) == 0) recv_gap = pick_gap(no_idle_recv);
    end
    out_ready_i <= r;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin : watch_ports
    pcm_out_t want;
    bit       any_fire;
    if (rst_ni) begin
      in_fire  = in_valid_i && in_ready_o;
      any_fire = in_fire;
      if (in_fire) expected_motion.push_back(predict_motion(in_data_i));
      if (cfg_valid_i && cfg_ready_o) begin
        any_fire = 1'b1;
        case (cfg_index_i)
          REG_SPEED_SCALE: speed_scale_q = cfg_data_i;
          REG_ACCEL_MAX_G: accel_max_g_q = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        any_fire = 1'b1;
        if (expected_motion.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result %p", out_data_o);
        end else begin
          want = expected_motion.pop_front();
          if (out_data_o.wave_valid !== want.wave_valid ||
              out_data_o.frequency_q8 !== want.frequency_q8 ||
              out_data_o.duty_q8 !== want.duty_q8 ||
              out_data_o.speed_q8 !== want.speed_q8 ||
              out_data_o.accel_q8 !== want.accel_q8) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("mismatch: exp v=%0d f=%h d=%h s=%h a=%h got v=%0d f=%h d=%h s=%h a=%h",
                       want.wave_valid, want.frequency_q8, want.duty_q8, want.speed_q8,
                       want.accel_q8, out_data_o.wave_valid, out_data_o.frequency_q8,
                       out_data_o.duty_q8, out_data_o.speed_q8, out_data_o.accel_q8);
          end
        end
      end
      if (any_fire) stall_cycles = 0;
      else stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_motion.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic add_edge(logic [31:0] t, logic lvl);
    pcm_in_t item;
    item.edge_time_us = t;
    item.new_level    = lvl;
    pending_edges.push_back(item);
  endtask

  task automatic wait_drained();
    while (pending_edges.size() > 0 || in_valid_i || expected_motion.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random_edges(int unsigned n);
    int unsigned k, sel;
    logic [31:0] per, hi;
    k = 0;
    while (k < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        add_edge($urandom, 1'($urandom_range(0, 1)));
        k++;
      end else begin
        per = pick_period();
        hi  = $urandom_range(per, 0);
        case ($urandom_range(0, 9))
          0: hi = per;
          1: hi = '0;
          default: ;
        endcase
        if (sel < 18) hi = per + $urandom_range(1, 50);
        if (sel >= 97) t_cur = $urandom;
        if ($urandom_range(0, 19) == 0) t_cur = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        add_edge(t_cur, 1'b1);
        k++;
        if (sel < 92) begin
          add_edge(t_cur + hi, 1'b0);
          k++;
        end
        t_cur = t_cur + per;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed edges at reset settings
    add_edge(32'h0000_0000, 1'b0);
    add_edge(32'hFFFF_FFFF, 1'b0);
    add_edge(32'd100, 1'b1);
    add_edge(32'd150, 1'b0);
    add_edge(32'd1100, 1'b1);
    add_edge(32'd1100, 1'b1);
    add_edge(32'd1100, 1'b0);
    add_edge(32'd1101, 1'b1);
    add_edge(32'd1102, 1'b0);
    add_edge(32'd1103, 1'b0);
    add_edge(32'hFFFF_FF00, 1'b1);
    add_edge(32'h0000_0040, 1'b0);
    add_edge(32'h0000_0100, 1'b1);
    add_edge(32'h0000_0000, 1'b1);
    add_edge(32'hFFFF_FFFF, 1'b1);
    add_edge(32'hFFFF_FFFE, 1'b0);
    add_edge(32'hFFFF_FFFF, 1'b0);
    add_edge(32'h5555_5555, 1'b1);
    add_edge(32'hAAAA_AAAA, 1'b1);
    add_edge(32'hD555_5554, 1'b0);
    add_edge(32'hAAAA_B2AA, 1'b1);
    add_edge(32'hAAAA_B000, 1'b0);
    wait_drained();

    // full-scale registers, long receiver hold-off
    write_reg(REG_SPEED_SCALE, 16'hFFFF);
    write_reg(REG_ACCEL_MAX_G, 16'hFFFF);
    queue_random_edges(170);
    hold_req = 1'b1;
    wait_drained();

    // zero registers, ignored write to an unmapped index
    write_reg(REG_SPEED_SCALE, 16'h0000);
    write_reg(REG_ACCEL_MAX_G, 16'h0000);
    write_reg(CFG_IDX_UNMAPPED, 16'($urandom));
    queue_random_edges(160);
    wait_drained();

    write_reg(REG_SPEED_SCALE, 16'($urandom));
    write_reg(REG_ACCEL_MAX_G, 16'($urandom));
    queue_random_edges(160);
    wait_drained();

    write_reg(REG_SPEED_SCALE, 16'd1);
    write_reg(CFG_IDX_UNMAPPED, 16'hFFFF);
    write_reg(REG_ACCEL_MAX_G, 16'd1);
    queue_random_edges(160);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_motion.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
